// ===== sv/segi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared defaults and the control bundle that travels down the pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int N_IN_FIELDS    = 8;

  typedef struct packed {
    logic valid;
    logic hit;
    logic negx;
    logic negy;
  } segi_ctl_t;

endpackage

// ===== sv/segi_front.sv =====
// ----------------------------------------------------------------------------
// Segment intersection front end
// Differences, cross products, sign normalization, range test and the
// magnitude-times-numerator products that seed the divider chain.
// ----------------------------------------------------------------------------
module segi_front #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int UW = 2 * C + 1,
  localparam int QB = C + FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [8*C-1:0]        pts_i,
  output segi_pkg::segi_ctl_t   ctl_o,
  output logic signed [C-1:0]   p1x_o,
  output logic signed [C-1:0]   p1y_o,
  output logic [UW-1:0]         den_o,
  output logic [UW-1:0]         rx_o,
  output logic [QB-1:0]         shx_o,
  output logic [UW-1:0]         ry_o,
  output logic [QB-1:0]         shy_o
);

  localparam int DW  = C + 1;
  localparam int PRW = 2 * C + 1;
  localparam int SW  = 2 * C + 2;
  localparam int MW  = 3 * C + 1;

  logic signed [C-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  assign asx = pts_i[0*C +: C];
  assign asy = pts_i[1*C +: C];
  assign aex = pts_i[2*C +: C];
  assign aey = pts_i[3*C +: C];
  assign bsx = pts_i[4*C +: C];
  assign bsy = pts_i[5*C +: C];
  assign bex = pts_i[6*C +: C];
  assign bey = pts_i[7*C +: C];

  logic [4:0] vld_q;

  // Stage 1: differences.
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, wx_q, wy_q;
  logic signed [C-1:0]  p1x1_q, p1y1_q;
  // Stage 2: products.
  logic signed [PRW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [DW-1:0]  dax2_q, day2_q;
  logic signed [C-1:0]   p1x2_q, p1y2_q;
  // Stage 3: cross products.
  logic signed [SW-1:0] den_q, nt_q, nu_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [C-1:0]  p1x3_q, p1y3_q;
  // Stage 4: normalized values.
  logic                 hit4_q, negx4_q, negy4_q;
  logic [UW-1:0]        den4_q, nt4_q;
  logic [C-1:0]         magx4_q, magy4_q;
  logic signed [C-1:0]  p1x4_q, p1y4_q;
  // Stage 5 outputs.
  logic                 hit5_q, negx5_q, negy5_q;
  logic [UW-1:0]        den5_q, rx5_q, ry5_q;
  logic [QB-1:0]        shx5_q, shy5_q;
  logic signed [C-1:0]  p1x5_q, p1y5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  logic signed [SW-1:0] den_n, nt_n, nu_n;
  logic signed [DW-1:0] magx_s, magy_s;
  logic                 neg_den;
  logic [MW-1:0]        prodx, prody;

  always_comb begin
    neg_den = den_q[SW-1];
    den_n   = neg_den ? -den_q : den_q;
    nt_n    = neg_den ? -nt_q  : nt_q;
    nu_n    = neg_den ? -nu_q  : nu_q;
    magx_s  = dax3_q[DW-1] ? -dax3_q : dax3_q;
    magy_s  = day3_q[DW-1] ? -day3_q : day3_q;
    prodx   = MW'(magx4_q) * MW'(nt4_q);
    prody   = MW'(magy4_q) * MW'(nt4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax_q  <= DW'(aex) - DW'(asx);
      day_q  <= DW'(aey) - DW'(asy);
      dbx_q  <= DW'(bex) - DW'(bsx);
      dby_q  <= DW'(bey) - DW'(bsy);
      wx_q   <= DW'(asx) - DW'(bsx);
      wy_q   <= DW'(asy) - DW'(bsy);
      p1x1_q <= asx;
      p1y1_q <= asy;

      m0_q   <= PRW'(dby_q) * PRW'(dax_q);
      m1_q   <= PRW'(dbx_q) * PRW'(day_q);
      m2_q   <= PRW'(dbx_q) * PRW'(wy_q);
      m3_q   <= PRW'(dby_q) * PRW'(wx_q);
      m4_q   <= PRW'(dax_q) * PRW'(wy_q);
      m5_q   <= PRW'(day_q) * PRW'(wx_q);
      dax2_q <= dax_q;
      day2_q <= day_q;
      p1x2_q <= p1x1_q;
      p1y2_q <= p1y1_q;

      den_q  <= SW'(m0_q) - SW'(m1_q);
      nt_q   <= SW'(m2_q) - SW'(m3_q);
      nu_q   <= SW'(m4_q) - SW'(m5_q);
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      p1x3_q <= p1x2_q;
      p1y3_q <= p1y2_q;

      // Both parameters must lie in [0,1] once the denominator is positive.
      hit4_q  <= (den_q != '0) && !nt_n[SW-1] && (nt_n <= den_n)
                 && !nu_n[SW-1] && (nu_n <= den_n);
      den4_q  <= den_n[UW-1:0];
      nt4_q   <= nt_n[UW-1:0];
      magx4_q <= magx_s[C-1:0];
      magy4_q <= magy_s[C-1:0];
      negx4_q <= dax3_q[DW-1];
      negy4_q <= day3_q[DW-1];
      p1x4_q  <= p1x3_q;
      p1y4_q  <= p1y3_q;

      // The high part of the dividend is already below the denominator, so
      // only the low magnitude bits and the fraction bits remain to shift in.
      hit5_q  <= hit4_q;
      den5_q  <= den4_q;
      rx5_q   <= prodx[MW-1:C];
      ry5_q   <= prody[MW-1:C];
      shx5_q  <= QB'(prodx[C-1:0]) << FRAC_BITS;
      shy5_q  <= QB'(prody[C-1:0]) << FRAC_BITS;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      p1x5_q  <= p1x4_q;
      p1y5_q  <= p1y4_q;
    end
  end

  always_comb begin
    ctl_o.valid = vld_q[4];
    ctl_o.hit   = hit5_q;
    ctl_o.negx  = negx5_q;
    ctl_o.negy  = negy5_q;
  end

  assign p1x_o = p1x5_q;
  assign p1y_o = p1y5_q;
  assign den_o = den5_q;
  assign rx_o  = rx5_q;
  assign ry_o  = ry5_q;
  assign shx_o = shx5_q;
  assign shy_o = shy5_q;

endmodule

// ===== sv/segi_cell.sv =====
// ----------------------------------------------------------------------------
// Segment intersection divider cell
// One restoring division step for the x and y lanes; passes the item on.
// ----------------------------------------------------------------------------
module segi_cell #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int UW = 2 * C + 1,
  localparam int QB = C + FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  segi_pkg::segi_ctl_t   ctl_i,
  input  logic signed [C-1:0]   p1x_i,
  input  logic signed [C-1:0]   p1y_i,
  input  logic [UW-1:0]         den_i,
  input  logic [UW-1:0]         rx_i,
  input  logic [QB-1:0]         shx_i,
  input  logic [UW-1:0]         ry_i,
  input  logic [QB-1:0]         shy_i,
  output segi_pkg::segi_ctl_t   ctl_o,
  output logic signed [C-1:0]   p1x_o,
  output logic signed [C-1:0]   p1y_o,
  output logic [UW-1:0]         den_o,
  output logic [UW-1:0]         rx_o,
  output logic [QB-1:0]         shx_o,
  output logic [UW-1:0]         ry_o,
  output logic [QB-1:0]         shy_o
);

  segi_pkg::segi_ctl_t ctl_q;
  logic signed [C-1:0] p1x_q, p1y_q;
  logic [UW-1:0]       den_q, rx_q, ry_q;
  logic [QB-1:0]       shx_q, shy_q;

  logic [UW:0] tx, ty, dfx, dfy;
  logic        gex, gey;

  always_comb begin
    tx  = {rx_i, shx_i[QB-1]};
    ty  = {ry_i, shy_i[QB-1]};
    dfx = tx - {1'b0, den_i};
    dfy = ty - {1'b0, den_i};
    gex = tx >= {1'b0, den_i};
    gey = ty >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // The remainder stays below the denominator, so the top bit drops out.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1x_q <= p1x_i;
      p1y_q <= p1y_i;
      den_q <= den_i;
      rx_q  <= gex ? dfx[UW-1:0] : tx[UW-1:0];
      ry_q  <= gey ? dfy[UW-1:0] : ty[UW-1:0];
      shx_q <= {shx_i[QB-2:0], gex};
      shy_q <= {shy_i[QB-2:0], gey};
    end
  end

  assign ctl_o = ctl_q;
  assign p1x_o = p1x_q;
  assign p1y_o = p1y_q;
  assign den_o = den_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign shx_o = shx_q;
  assign shy_o = shy_q;

endmodule

// ===== sv/segment_intersection.sv =====
// ----------------------------------------------------------------------------
// Segment intersection
// Tests two segments for a crossing and gives the crossing point.
// ----------------------------------------------------------------------------
// One segment pair is taken per cycle and one result leaves per cycle, in
// order, unless the output side stalls. The pipeline holds five front stages
// (differences, products, cross products, range test, seed products), one
// divider cell per quotient bit, and the output register. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// a stall on the output side holds every item in place. Parallel and
// degenerate pairs report no hit, and a miss reports zero coordinates.
module segment_intersection #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF,
  localparam int C      = COORD_BITS,
  localparam int UW     = 2 * C + 1,
  localparam int QB     = C + FRAC_BITS,
  localparam int OW     = C + FRAC_BITS,
  localparam int IN_W   = ((segi_pkg::N_IN_FIELDS * C + 7) / 8) * 8,
  localparam int OUT_W  = ((2 * OW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x,
  // b_end_y, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // cross_x, cross_y, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  // hit
  output logic             m_axis_tuser
);

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  segi_pkg::segi_ctl_t ctl_w [QB+1];
  logic signed [C-1:0] p1x_w [QB+1];
  logic signed [C-1:0] p1y_w [QB+1];
  logic [UW-1:0]       den_w [QB+1];
  logic [UW-1:0]       rx_w  [QB+1];
  logic [UW-1:0]       ry_w  [QB+1];
  logic [QB-1:0]       shx_w [QB+1];
  logic [QB-1:0]       shy_w [QB+1];

  segi_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .pts_i  (s_axis_tdata[segi_pkg::N_IN_FIELDS*C-1:0]),
    .ctl_o  (ctl_w[0]),
    .p1x_o  (p1x_w[0]),
    .p1y_o  (p1y_w[0]),
    .den_o  (den_w[0]),
    .rx_o   (rx_w[0]),
    .shx_o  (shx_w[0]),
    .ry_o   (ry_w[0]),
    .shy_o  (shy_w[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    segi_cell #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl_w[i]),
      .p1x_i (p1x_w[i]),
      .p1y_i (p1y_w[i]),
      .den_i (den_w[i]),
      .rx_i  (rx_w[i]),
      .shx_i (shx_w[i]),
      .ry_i  (ry_w[i]),
      .shy_i (shy_w[i]),
      .ctl_o (ctl_w[i+1]),
      .p1x_o (p1x_w[i+1]),
      .p1y_o (p1y_w[i+1]),
      .den_o (den_w[i+1]),
      .rx_o  (rx_w[i+1]),
      .shx_o (shx_w[i+1]),
      .ry_o  (ry_w[i+1]),
      .shy_o (shy_w[i+1])
    );
  end

  segi_pkg::segi_ctl_t ctl_end;
  assign ctl_end = ctl_w[QB];

  // Apply the quotient to the start point and truncate toward zero.
  logic signed [OW+1:0] basex, basey, sumx, sumy, fixx, fixy;

  always_comb begin
    basex = (OW + 2)'(p1x_w[QB]) <<< FRAC_BITS;
    basey = (OW + 2)'(p1y_w[QB]) <<< FRAC_BITS;
    sumx  = ctl_end.negx ? basex - $signed({2'b00, shx_w[QB]})
                         : basex + $signed({2'b00, shx_w[QB]});
    sumy  = ctl_end.negy ? basey - $signed({2'b00, shy_w[QB]})
                         : basey + $signed({2'b00, shy_w[QB]});
    fixx  = sumx;
    fixy  = sumy;
    if (rx_w[QB] != '0) begin
      if (ctl_end.negx && sumx > 0) begin
        fixx = sumx - (OW + 2)'(1);
      end else if (!ctl_end.negx && sumx < 0) begin
        fixx = sumx + (OW + 2)'(1);
      end
    end
    if (ry_w[QB] != '0) begin
      if (ctl_end.negy && sumy > 0) begin
        fixy = sumy - (OW + 2)'(1);
      end else if (!ctl_end.negy && sumy < 0) begin
        fixy = sumy + (OW + 2)'(1);
      end
    end
  end

  logic          hit_q;
  logic [OW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl_end.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= ctl_end.hit;
      cx_q  <= ctl_end.hit ? fixx[OW-1:0] : '0;
      cy_q  <= ctl_end.hit ? fixy[OW-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = OUT_W'({cy_q, cx_q});

  // A miss always leaves with a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (cx_q == '0 && cy_q == '0))
    else $error("miss result carries a nonzero point");

  // The input side is open exactly when the output register can move.
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output register");

  // The last cell always leaves a remainder below the denominator.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_end.valid && ctl_end.hit) |-> (rx_w[QB] < den_w[QB] && ry_w[QB] < den_w[QB]))
    else $error("divider remainder out of range");

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule
